@@ rtl/lchr_pkg.sv @@
// Package for the LED current hysteresis regulator: beat types, register map, reset values.
`timescale 1ns / 1ps

package lchr_pkg;

	// Input beat: one current-sense sample plus the blink level
	typedef struct packed {
		logic [7:0] sense_sample;
		logic       blink_level;
	} sample_beat_t;

	// Result beat: duty value and shutdown flag
	typedef struct packed {
		logic [7:0] duty;
		logic       shutdown;
	} result_beat_t;

	// Register map (word index, byte address = 4 * index)
	localparam int RegIdxW = 3;
	localparam int PaddrW  = RegIdxW + 2;

	localparam logic [RegIdxW-1:0] REG_NORMAL_LOW   = 3'd0;
	localparam logic [RegIdxW-1:0] REG_BRIGHT_LOW   = 3'd1;
	localparam logic [RegIdxW-1:0] REG_HYSTERESIS   = 3'd2;
	localparam logic [RegIdxW-1:0] REG_PANIC_LEVEL  = 3'd3;
	localparam logic [RegIdxW-1:0] REG_FAST_GAP     = 3'd4;
	localparam logic [RegIdxW-1:0] REG_FAST_STEP    = 3'd5;
	localparam logic [RegIdxW-1:0] REG_PANIC_LIMIT  = 3'd6;
	localparam logic [RegIdxW-1:0] REG_SETTLE_COUNT = 3'd7;

	// Register reset values
	localparam logic [7:0] NORMAL_LOW_RST   = 8'd30;
	localparam logic [7:0] BRIGHT_LOW_RST   = 8'd75;
	localparam logic [7:0] HYSTERESIS_RST   = 8'd10;
	localparam logic [7:0] PANIC_LEVEL_RST  = 8'd225;
	localparam logic [7:0] FAST_GAP_RST     = 8'd30;
	localparam logic [7:0] FAST_STEP_RST    = 8'd10;
	localparam logic [5:0] PANIC_LIMIT_RST  = 6'd50;
	localparam logic [3:0] SETTLE_COUNT_RST = 4'd3;

	// Saturation points
	localparam logic [7:0] DUTY_MAX      = 8'd255;
	localparam logic [5:0] PANIC_CNT_MAX = 6'd63;
	localparam logic [4:0] SETTLE_CNT_MAX = 5'd16;

endpackage

@@ rtl/led_current_hysteresis_regulator.sv @@
// Top level of the LED current hysteresis regulator: config registers, datapath, result register.
// Path: a sample beat is captured in the input register, then moves on into the result register.
// Throughput: one beat per cycle while result_stall is low; the duty/panic/settle update is
// combinational between input and result registers, so the next sample sees the updated state at once.
// Reset (arst_n low): registers return to their defaults, duty, counters and shutdown latch clear,
// and both pipeline stages empty. Shutdown clears only through reset.
`timescale 1ns / 1ps

module led_current_hysteresis_regulator (
	input  logic                         clk,
	input  logic                         arst_n,
	// sample channel
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  lchr_pkg::sample_beat_t       sample_beat,
	// result channel
	output logic                         result_valid,
	input  logic                         result_stall,
	output lchr_pkg::result_beat_t       result_beat,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lchr_pkg::PaddrW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// Configuration registers
	logic [7:0] normal_low_q, bright_low_q, hysteresis_q, panic_level_q;
	logic [7:0] fast_gap_q, fast_step_q;
	logic [5:0] panic_limit_q;
	logic [3:0] settle_count_q;

	// Regulator state
	logic [7:0] duty_q;
	logic [4:0] settle_cnt_q;
	logic [5:0] panic_cnt_q;
	logic       halted_q;

	// Pipeline
	logic                   valid_s1;
	lchr_pkg::sample_beat_t beat_s1;
	logic                   out_valid_q;
	lchr_pkg::result_beat_t out_q;

	logic                        advance;
	logic                        cfg_wr;
	logic [lchr_pkg::RegIdxW-1:0] reg_idx;

	// Next-state signals
	logic [7:0] lower;
	logic [8:0] upper;
	logic       act;
	logic [7:0] shortfall;
	logic [7:0] step;
	logic [8:0] duty_sum;
	logic [7:0] duty_inc;
	logic [7:0] duty_dec;
	logic [7:0] duty_nx;
	logic [5:0] panic_nx;
	logic [4:0] settle_nx;
	logic       halted_nx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[lchr_pkg::PaddrW-1:2];

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_low_q   <= lchr_pkg::NORMAL_LOW_RST;
			bright_low_q   <= lchr_pkg::BRIGHT_LOW_RST;
			hysteresis_q   <= lchr_pkg::HYSTERESIS_RST;
			panic_level_q  <= lchr_pkg::PANIC_LEVEL_RST;
			fast_gap_q     <= lchr_pkg::FAST_GAP_RST;
			fast_step_q    <= lchr_pkg::FAST_STEP_RST;
			panic_limit_q  <= lchr_pkg::PANIC_LIMIT_RST;
			settle_count_q <= lchr_pkg::SETTLE_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				lchr_pkg::REG_NORMAL_LOW:   normal_low_q   <= pwdata[7:0];
				lchr_pkg::REG_BRIGHT_LOW:   bright_low_q   <= pwdata[7:0];
				lchr_pkg::REG_HYSTERESIS:   hysteresis_q   <= pwdata[7:0];
				lchr_pkg::REG_PANIC_LEVEL:  panic_level_q  <= pwdata[7:0];
				lchr_pkg::REG_FAST_GAP:     fast_gap_q     <= pwdata[7:0];
				lchr_pkg::REG_FAST_STEP:    fast_step_q    <= pwdata[7:0];
				lchr_pkg::REG_PANIC_LIMIT:  panic_limit_q  <= pwdata[5:0];
				lchr_pkg::REG_SETTLE_COUNT: settle_count_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Config readback
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			lchr_pkg::REG_NORMAL_LOW:   prdata[7:0] = normal_low_q;
			lchr_pkg::REG_BRIGHT_LOW:   prdata[7:0] = bright_low_q;
			lchr_pkg::REG_HYSTERESIS:   prdata[7:0] = hysteresis_q;
			lchr_pkg::REG_PANIC_LEVEL:  prdata[7:0] = panic_level_q;
			lchr_pkg::REG_FAST_GAP:     prdata[7:0] = fast_gap_q;
			lchr_pkg::REG_FAST_STEP:    prdata[7:0] = fast_step_q;
			lchr_pkg::REG_PANIC_LIMIT:  prdata[5:0] = panic_limit_q;
			lchr_pkg::REG_SETTLE_COUNT: prdata[3:0] = settle_count_q;
			default: ;
		endcase
	end

	// Handshake: stage 1 moves into the result register when that is free or being drained
	assign advance      = valid_s1 && (!out_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign result_valid = out_valid_q;
	assign result_beat  = out_q;

	// Regulator update for the beat in stage 1
	always_comb begin
		lower     = beat_s1.blink_level ? bright_low_q : normal_low_q;
		upper     = {1'b0, lower} + {1'b0, hysteresis_q};
		act       = settle_cnt_q > {1'b0, settle_count_q};
		shortfall = lower - beat_s1.sense_sample;
		step      = (shortfall > fast_gap_q) ? fast_step_q : 8'd1;
		duty_sum  = {1'b0, duty_q} + {1'b0, step};
		duty_inc  = duty_sum[8] ? lchr_pkg::DUTY_MAX : duty_sum[7:0];
		duty_dec  = (duty_q == 8'd0) ? 8'd0 : duty_q - 8'd1;

		duty_nx   = duty_q;
		panic_nx  = panic_cnt_q;
		settle_nx = settle_cnt_q + 5'd1;
		if (act) begin
			settle_nx = '0;
			if (beat_s1.sense_sample > panic_level_q) begin
				duty_nx = duty_dec;
				if (panic_cnt_q != lchr_pkg::PANIC_CNT_MAX)
					panic_nx = panic_cnt_q + 6'd1;
			end else if (beat_s1.sense_sample < lower) begin
				duty_nx  = duty_inc;
				panic_nx = '0;
			end else if ({1'b0, beat_s1.sense_sample} > upper) begin
				duty_nx = duty_dec;
			end else begin
				panic_nx = '0;
			end
		end

		halted_nx = panic_nx >= panic_limit_q;
		if (halted_nx)
			duty_nx = '0;

		// frozen once shut down
		if (halted_q) begin
			duty_nx   = duty_q;
			panic_nx  = panic_cnt_q;
			settle_nx = settle_cnt_q;
			halted_nx = 1'b1;
		end
	end

	// Control, state and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			duty_q       <= '0;
			settle_cnt_q <= '0;
			panic_cnt_q  <= '0;
			halted_q     <= 1'b0;
		end else begin
			if (!sample_stall)
				valid_s1 <= sample_valid;
			if (advance) begin
				out_valid_q  <= 1'b1;
				duty_q       <= duty_nx;
				settle_cnt_q <= settle_nx;
				panic_cnt_q  <= panic_nx;
				halted_q     <= halted_nx;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!sample_stall)
			beat_s1 <= sample_beat;
		if (advance) begin
			out_q.duty     <= halted_nx ? 8'd0 : duty_nx;
			out_q.shutdown <= halted_nx;
		end
	end

	// Checks
	a_shutdown_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.shutdown |-> result_beat.duty == 8'd0)
		else $error("shutdown result with nonzero duty");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("shutdown latch cleared without reset");

	a_halt_duty: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> duty_q == 8'd0)
		else $error("duty nonzero while halted");

	a_settle_range: assert property (@(posedge clk) disable iff (!arst_n)
		settle_cnt_q <= lchr_pkg::SETTLE_CNT_MAX)
		else $error("settle counter out of range");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("beat advanced but no result presented");

endmodule

@@ bench/lchr_checker.sv @@
// Scoreboard for the LED current regulator: tracks registers and state, checks every result beat.
`timescale 1ns / 1ps

module lchr_checker
	import lchr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  sample_beat_t       sample_beat,
	input  logic               result_valid,
	input  logic               result_stall,
	input  result_beat_t       result_beat,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PaddrW-1:0]  paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending
);

	// Register copies, updated from observed APB writes
	logic [7:0] normal_low_q, bright_low_q, hyst_q, panic_level_q, fast_gap_q, fast_step_q;
	logic [5:0] panic_limit_q;
	logic [3:0] settle_count_q;

	// Regulator state
	logic [7:0] duty_lvl;
	logic [4:0] settle_cnt;
	logic [5:0] panic_cnt;
	logic       halted;

	result_beat_t expected_results[$];
	int           fails = 0;

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fails++;
	endtask

	function automatic logic [31:0] reg_value(logic [RegIdxW-1:0] idx);
		case (idx)
			REG_NORMAL_LOW:   return {24'd0, normal_low_q};
			REG_BRIGHT_LOW:   return {24'd0, bright_low_q};
			REG_HYSTERESIS:   return {24'd0, hyst_q};
			REG_PANIC_LEVEL:  return {24'd0, panic_level_q};
			REG_FAST_GAP:     return {24'd0, fast_gap_q};
			REG_FAST_STEP:    return {24'd0, fast_step_q};
			REG_PANIC_LIMIT:  return {26'd0, panic_limit_q};
			REG_SETTLE_COUNT: return {28'd0, settle_count_q};
			default:          return '0;
		endcase
	endfunction

	// One sample through the regulator: updates state, returns the result beat
	function automatic result_beat_t regulate(sample_beat_t b);
		logic [7:0]   lower;
		logic [7:0]   shortfall;
		logic [8:0]   upper;
		logic [8:0]   sum;
		result_beat_t r;
		if (!halted) begin
			if (settle_cnt > {1'b0, settle_count_q}) begin
				lower = b.blink_level ? bright_low_q : normal_low_q;
				upper = {1'b0, lower} + {1'b0, hyst_q};
				if (b.sense_sample > panic_level_q) begin
					// overcurrent: back off and count toward shutdown
					if (duty_lvl != 8'd0)
						duty_lvl = duty_lvl - 8'd1;
					if (panic_cnt != PANIC_CNT_MAX)
						panic_cnt = panic_cnt + 6'd1;
				end else if (b.sense_sample < lower) begin
					shortfall = lower - b.sense_sample;
					sum = {1'b0, duty_lvl} +
						((shortfall > fast_gap_q) ? {1'b0, fast_step_q} : 9'd1);
					duty_lvl = sum[8] ? DUTY_MAX : sum[7:0];
					panic_cnt = '0;
				end else if ({1'b0, b.sense_sample} > upper) begin
					if (duty_lvl != 8'd0)
						duty_lvl = duty_lvl - 8'd1;
				end else begin
					panic_cnt = '0;
				end
				settle_cnt = '0;
			end else begin
				settle_cnt = settle_cnt + 5'd1;
			end
			if (panic_cnt >= panic_limit_q) begin
				halted = 1'b1;
				duty_lvl = '0;
			end
		end
		r.duty = halted ? 8'd0 : duty_lvl;
		r.shutdown = halted;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_beat_t want;
		if (!arst_n) begin
			normal_low_q = NORMAL_LOW_RST;
			bright_low_q = BRIGHT_LOW_RST;
			hyst_q = HYSTERESIS_RST;
			panic_level_q = PANIC_LEVEL_RST;
			fast_gap_q = FAST_GAP_RST;
			fast_step_q = FAST_STEP_RST;
			panic_limit_q = PANIC_LIMIT_RST;
			settle_count_q = SETTLE_COUNT_RST;
			duty_lvl = '0;
			settle_cnt = '0;
			panic_cnt = '0;
			halted = 1'b0;
			expected_results.delete();
			pending <= 0;
		end else begin
			// register port: track writes, check read data
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[PaddrW-1:2])
						REG_NORMAL_LOW:   normal_low_q = pwdata[7:0];
						REG_BRIGHT_LOW:   bright_low_q = pwdata[7:0];
						REG_HYSTERESIS:   hyst_q = pwdata[7:0];
						REG_PANIC_LEVEL:  panic_level_q = pwdata[7:0];
						REG_FAST_GAP:     fast_gap_q = pwdata[7:0];
						REG_FAST_STEP:    fast_step_q = pwdata[7:0];
						REG_PANIC_LIMIT:  panic_limit_q = pwdata[5:0];
						REG_SETTLE_COUNT: settle_count_q = pwdata[3:0];
						default: ;
					endcase
				end else if (prdata !== reg_value(paddr[PaddrW-1:2])) begin
					report_mismatch($sformatf("register %0d read %0h, want %0h",
						paddr[PaddrW-1:2], prdata, reg_value(paddr[PaddrW-1:2])));
				end
			end

			// result beat against the oldest expectation
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat duty %0d shutdown %0b",
						result_beat.duty, result_beat.shutdown));
				end else begin
					want = expected_results.pop_front();
					if (result_beat.duty !== want.duty)
						report_mismatch($sformatf("duty %0d, want %0d",
							result_beat.duty, want.duty));
					if (result_beat.shutdown !== want.shutdown)
						report_mismatch($sformatf("shutdown %0b, want %0b",
							result_beat.shutdown, want.shutdown));
				end
			end

			// sample beat: predict its result
			if (sample_valid && !sample_stall)
				expected_results.push_back(regulate(sample_beat));

			pending <= expected_results.size();
			fail_count <= fails;
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the LED current regulator: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module tb_top;
	import lchr_pkg::*;

	localparam int HOLD_CYCLES  = 80;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RAND_PHASES  = 7;
	localparam int PHASE_ITEMS  = 140;
	localparam int HALT_ITEMS   = 200;
	localparam int TAIL_ITEMS   = 30;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	sample_beat_t       sample_beat = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_beat_t       result_beat;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PaddrW-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int         fail_count;
	int         pending;
	int         idle_cycles = 0;
	logic [7:0] reg_shadow [8];
	bit         quiet = 1'b0;
	bit         send_gaps = 1'b1;
	bit         stall_gaps = 1'b1;
	bit         hold_req = 1'b0;

	always #5 clk = ~clk;

	led_current_hysteresis_regulator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_beat  (sample_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	lchr_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_beat  (sample_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Watchdog: too long without any beat or register transfer ends the run
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (stall_gaps && !quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Setup then access phase, then an idle phase so psel never toggles within a step
	task automatic apb_access(logic wr, logic [RegIdxW-1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [RegIdxW-1:0] idx, logic [7:0] val);
		reg_shadow[idx] = val;
		apb_access(1'b1, idx, {24'd0, val});
	endtask

	task automatic read_all_regs();
		for (int i = 0; i < 8; i++)
			apb_access(1'b0, RegIdxW'(i), '0);
	endtask

	// Offer one sample beat and hold it until taken
	task automatic send_sample(logic [7:0] s, logic bl);
		sample_beat_t b;
		if (send_gaps && !quiet && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		b.sense_sample = s;
		b.blink_level = bl;
		sample_valid <= 1'b1;
		sample_beat <= b;
		do @(posedge clk); while (sample_stall);
	endtask

	// Settle count 0: every second sample is acted on
	task automatic send_pair(logic [7:0] s, logic bl);
		send_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_sample(s, bl);
	endtask

	// Stop offering and wait until every result beat is back
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Samples clustered around the set points, with zeros to keep the panic count low
	function automatic logic [7:0] gen_sample(logic bl);
		int lower, hyst, gap, s, r;
		lower = bl ? reg_shadow[REG_BRIGHT_LOW] : reg_shadow[REG_NORMAL_LOW];
		hyst = reg_shadow[REG_HYSTERESIS];
		gap = reg_shadow[REG_FAST_GAP];
		r = $urandom_range(0, 99);
		if (r < 15)
			s = 0;
		else if (r < 20)
			s = 255;
		else if (r < 45)
			s = lower - int'($urandom_range(0, 2 * gap + 2));
		else if (r < 70)
			s = lower + int'($urandom_range(0, hyst));
		else if (r < 85)
			s = lower + hyst + int'($urandom_range(1, 8));
		else
			s = $urandom_range(0, 255);
		if (s < 0)
			s = 0;
		if (s > 255)
			s = 255;
		return 8'(s);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// New register set; the last one is aimed at reaching shutdown
	task automatic configure_random(bit to_halt);
		logic [7:0] limit;
		logic [7:0] settle;
		write_reg(REG_NORMAL_LOW, pick_byte());
		write_reg(REG_BRIGHT_LOW, pick_byte());
		write_reg(REG_HYSTERESIS, pick_byte());
		write_reg(REG_FAST_GAP, pick_byte());
		write_reg(REG_FAST_STEP, pick_byte());
		if (to_halt) begin
			write_reg(REG_PANIC_LEVEL, 8'($urandom_range(0, 254)));
			case ($urandom_range(0, 3))
				0:       limit = 8'd0;
				1:       limit = 8'd1;
				2:       limit = 8'd63;
				default: limit = 8'($urandom_range(1, 63));
			endcase
			settle = 8'($urandom_range(0, 1));
		end else begin
			write_reg(REG_PANIC_LEVEL, pick_byte());
			limit = $urandom_range(0, 1) ? 8'd63 : 8'($urandom_range(40, 63));
			case ($urandom_range(0, 5))
				0:       settle = 8'd0;
				1:       settle = 8'd15;
				default: settle = 8'($urandom_range(0, 3));
			endcase
		end
		write_reg(REG_PANIC_LIMIT, limit);
		write_reg(REG_SETTLE_COUNT, settle);
		read_all_regs();
	endtask

	initial begin
		logic bl;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_all_regs();

		// Directed, settle 0: panic at zero duty, zero fast step, slow step,
		// band with an upper set point past 255
		write_reg(REG_NORMAL_LOW, 8'd100);
		write_reg(REG_BRIGHT_LOW, 8'd250);
		write_reg(REG_HYSTERESIS, 8'd255);
		write_reg(REG_PANIC_LEVEL, 8'd254);
		write_reg(REG_FAST_GAP, 8'd20);
		write_reg(REG_FAST_STEP, 8'd0);
		write_reg(REG_PANIC_LIMIT, 8'd63);
		write_reg(REG_SETTLE_COUNT, 8'd0);
		read_all_regs();
		send_pair(8'd255, 1'b0);
		send_pair(8'd0, 1'b0);
		send_pair(8'd90, 1'b0);
		send_pair(8'd254, 1'b1);
		drain();

		// Directed: long settle, then lowered under the running count; duty to 255 and one step back down
		write_reg(REG_NORMAL_LOW, 8'd0);
		write_reg(REG_BRIGHT_LOW, 8'd255);
		write_reg(REG_HYSTERESIS, 8'd0);
		write_reg(REG_PANIC_LEVEL, 8'd255);
		write_reg(REG_FAST_GAP, 8'd0);
		write_reg(REG_FAST_STEP, 8'd255);
		write_reg(REG_SETTLE_COUNT, 8'd15);
		repeat (6) send_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		drain();
		write_reg(REG_SETTLE_COUNT, 8'd3);
		send_sample(8'd0, 1'b1);
		repeat (4) send_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_sample(8'd255, 1'b0);
		drain();

		// Random phases
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			configure_random(1'b0);
			send_gaps = ($urandom_range(0, 3) != 0);
			stall_gaps = ($urandom_range(0, 3) != 0);
			if (ph == 2)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				bl = 1'($urandom_range(0, 1));
				send_sample(gen_sample(bl), bl);
			end
			drain();
		end

		// Last part, no idling: drive into shutdown and check the outputs stay frozen
		quiet = 1'b1;
		configure_random(1'b1);
		repeat (HALT_ITEMS) send_sample(8'd255, 1'($urandom_range(0, 1)));
		repeat (TAIL_ITEMS) begin
			bl = 1'($urandom_range(0, 1));
			send_sample(gen_sample(bl), bl);
		end
		drain();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
